[rtl/core/werc_pkg.sv]
// Shared types and constants for the windowed event rate counter.
package werc_pkg;

    localparam int NOW_W    = 32;
    localparam int WINDOW_W = 31;
    localparam int SCALE_W  = 24;
    localparam int COUNT_W  = 6;
    localparam int RATE_W   = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_MINUTE_SCALE = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd60000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD
    } t_state;

    // ring port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ring_ctl;

    // sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic load;
    } t_seq_stat;

endpackage

[rtl/core/werc_ring.sv]
// Timestamp ring memory: one write port, one registered read port.
module werc_ring #(
    parameter int RING_DEPTH = 32,
    parameter int ADDR_W     = 5
) (
    input  logic                       i_clk,
    input  werc_pkg::t_ring_ctl        i_ctl,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [werc_pkg::NOW_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [werc_pkg::NOW_W-1:0] o_rd_data
);

    logic [werc_pkg::NOW_W-1:0] r_mem [RING_DEPTH];
    logic [werc_pkg::NOW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/werc_seq.sv]
// Scan sequencer: ring pointers, read issue, shared age compare and hit counter.
module werc_seq #(
    parameter int RING_DEPTH = 32,
    parameter int ADDR_W     = 5,
    parameter int CNT_W      = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [werc_pkg::NOW_W-1:0]    i_now_ms,
    input  logic                          i_event_seen,
    input  logic [werc_pkg::WINDOW_W-1:0] i_window_ms,
    input  logic                          i_out_free,
    output werc_pkg::t_seq_stat           o_stat,
    output werc_pkg::t_ring_ctl           o_ring_ctl,
    output logic [ADDR_W-1:0]             o_waddr,
    output logic [werc_pkg::NOW_W-1:0]    o_wdata,
    output logic [ADDR_W-1:0]             o_raddr,
    input  logic [werc_pkg::NOW_W-1:0]    i_rd_data,
    output logic [CNT_W-1:0]              o_count
);

    werc_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]          r_wslot;
    logic [CNT_W-1:0]           r_filled;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_pend;
    logic [CNT_W-1:0]           r_cnt;
    logic [werc_pkg::NOW_W-1:0] r_now;

    logic                       accept;
    logic                       issue;
    logic [werc_pkg::NOW_W-1:0] age;
    logic                       hit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            werc_pkg::ST_IDLE: if (i_valid) n_state = werc_pkg::ST_SCAN;
            werc_pkg::ST_SCAN: if (!issue && !r_pend) n_state = werc_pkg::ST_LOAD;
            werc_pkg::ST_LOAD: if (i_out_free) n_state = werc_pkg::ST_IDLE;
            default:           n_state = werc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stat.idle = 1'b0;
        o_stat.load = 1'b0;
        accept      = 1'b0;
        issue       = 1'b0;
        unique case (r_state)
            werc_pkg::ST_IDLE: begin
                o_stat.idle = 1'b1;
                accept      = i_valid;
            end
            werc_pkg::ST_SCAN: issue = (r_idx < r_filled);
            werc_pkg::ST_LOAD: o_stat.load = i_out_free;
            default: ;
        endcase
    end

    // shared compare: wrapping age against the window
    assign age = r_now - i_rd_data;
    assign hit = (age <= {1'b0, i_window_ms});

    assign o_ring_ctl.wr_en = accept && i_event_seen;
    assign o_ring_ctl.rd_en = issue;
    assign o_waddr          = r_wslot;
    assign o_wdata          = i_now_ms;
    assign o_raddr          = r_idx[ADDR_W-1:0];
    assign o_count          = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= werc_pkg::ST_IDLE;
            r_wslot  <= '0;
            r_filled <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_cnt  <= '0;
                if (i_event_seen) begin
                    r_wslot <= (r_wslot == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                    if (r_filled != CNT_W'(RING_DEPTH)) begin
                        r_filled <= r_filled + 1'b1;
                    end
                end
            end else begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pend && hit) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_now_ms;
        end
    end

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == werc_pkg::ST_SCAN))
        else $error("read pending outside scan");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_filled)
        else $error("hit count exceeds filled entries");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == werc_pkg::ST_SCAN && r_cnt == '0))
        else $error("accepted word did not start a scan");

endmodule

[rtl/core/windowed_event_rate_counter_core.sv]
// Top level of the windowed event rate counter: config, sequencer, ring, output stage.
//
// Input channel: i_valid / o_stall with i_now_ms and i_event_seen. A word is taken
// at a clock edge with i_valid high and o_stall low. A word with i_event_seen set
// first stores i_now_ms in the timestamp ring (oldest entry overwritten once full),
// then every filled entry is checked: it counts if now minus its stamp, as a
// wrapping 32-bit difference, is at most window_ms.
// Output channel: o_valid / i_stall with o_events_in_window and o_rate_per_minute
// (count times per_minute_scale, Q.8). A word is taken when o_valid is high and
// i_stall low; it sits in the output register while the receiver stalls, and the
// next input word is still taken and scanned meanwhile.
// Timing: after accept the sequencer scans every filled entry, then loads the result
// into the output register. The ring read port sets the scan pace: one entry is read and
// compared per cycle, each compare on the registered read data; the load waits for a free output register.
// One word is in flight at a time, so o_stall is high from accept until the result
// loads; the next word is taken once the sequencer is idle again.
// Config: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index 0 = window_ms,
// 1 = per_minute_scale, other indexes ignored. Write only while idle.
// Reset (synchronous, active low): ring empty, write slot zero, window 60000,
// scale 256. Ring contents are not cleared; only written entries are ever read.
module windowed_event_rate_counter_core #(
    parameter int RING_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [werc_pkg::NOW_W-1:0]      i_now_ms,
    input  logic                            i_event_seen,
    // result words
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [werc_pkg::COUNT_W-1:0]    o_events_in_window,
    output logic [werc_pkg::RATE_W-1:0]     o_rate_per_minute,
    // config writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [werc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [werc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // address needs at least one bit; counter must hold the depth itself
    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int PROD_W = CNT_W + werc_pkg::SCALE_W;

    logic [werc_pkg::WINDOW_W-1:0] r_window_ms;
    logic [werc_pkg::SCALE_W-1:0]  r_scale;

    logic                          r_out_valid;
    logic [werc_pkg::COUNT_W-1:0]  r_count;
    logic [werc_pkg::RATE_W-1:0]   r_rate;

    werc_pkg::t_seq_stat           seq_stat;
    werc_pkg::t_ring_ctl           ring_ctl;
    logic [ADDR_W-1:0]             waddr;
    logic [ADDR_W-1:0]             raddr;
    logic [werc_pkg::NOW_W-1:0]    wdata;
    logic [werc_pkg::NOW_W-1:0]    rd_data;
    logic [CNT_W-1:0]              seq_cnt;

    logic                          out_free;
    logic [PROD_W-1:0]             prod;
    logic [CNT_W+werc_pkg::COUNT_W-1:0]  cnt_ext;
    logic [PROD_W+werc_pkg::RATE_W-1:0]  prod_ext;

    // config registers; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= werc_pkg::WINDOW_RESET;
            r_scale     <= werc_pkg::SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                werc_pkg::CFG_WINDOW_MS:
                    r_window_ms <= i_cfg_data[werc_pkg::WINDOW_W-1:0];
                werc_pkg::CFG_PER_MINUTE_SCALE:
                    r_scale <= i_cfg_data[werc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    werc_seq #(
        .RING_DEPTH (RING_DEPTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_now_ms     (i_now_ms),
        .i_event_seen (i_event_seen),
        .i_window_ms  (r_window_ms),
        .i_out_free   (out_free),
        .o_stat       (seq_stat),
        .o_ring_ctl   (ring_ctl),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rd_data    (rd_data),
        .o_count      (seq_cnt)
    );

    werc_ring #(
        .RING_DEPTH (RING_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctl     (ring_ctl),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr   (raddr),
        .o_rd_data (rd_data)
    );

    assign o_stall = !seq_stat.idle;

    // output register frees up when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;

    // rate: count times scale, masked to the field width
    assign prod     = PROD_W'(seq_cnt) * PROD_W'(r_scale);
    assign cnt_ext  = {{werc_pkg::COUNT_W{1'b0}}, seq_cnt};
    assign prod_ext = {{werc_pkg::RATE_W{1'b0}}, prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.load) begin
            r_count <= cnt_ext[werc_pkg::COUNT_W-1:0];
            r_rate  <= prod_ext[werc_pkg::RATE_W-1:0];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_events_in_window = r_count;
    assign o_rate_per_minute  = r_rate;

endmodule
